### rtl/core/pfse_pkg.sv
package pfse_pkg;

  // Square geometry.
  localparam int SQUARE_SIDE  = 5;
  localparam int SQUARE_CELLS = SQUARE_SIDE * SQUARE_SIDE;
  localparam int ALPHABET     = 26;
  localparam int CELL_W       = $clog2(SQUARE_CELLS);
  localparam int CODE_W       = $clog2(ALPHABET);
  localparam int RC_W         = $clog2(SQUARE_SIDE);

  // Letter codes, A is zero.
  localparam logic [CODE_W-1:0] CODE_I = CODE_W'(8);
  localparam logic [CODE_W-1:0] CODE_J = CODE_W'(9);
  localparam logic [CODE_W-1:0] CODE_X = CODE_W'(23);
  localparam logic [CODE_W-1:0] CODE_Z = CODE_W'(25);
  localparam logic [5:0]        NO_LETTER = 6'd63;

  // ASCII constants.
  localparam logic [7:0] ASCII_UC_A = 8'h41;
  localparam logic [7:0] ASCII_UC_Z = 8'h5A;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_Z = 8'h7A;

  // Mode codes of an input item.
  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_MSG  = 2'd2;

  // Position of a letter in the square.
  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pos_t;

  // Decoded input byte.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } letter_t;

  // Upper-cases a letter, folds J to I, and flags any non-letter.
  function automatic letter_t letter_decode(input logic [7:0] ch);
    letter_t res;
    res.valid = 1'b0;
    res.code  = '0;
    if (ch >= ASCII_UC_A && ch <= ASCII_UC_Z) begin
      res.valid = 1'b1;
      res.code  = CODE_W'(ch - ASCII_UC_A);
    end else if (ch >= ASCII_LC_A && ch <= ASCII_LC_Z) begin
      res.valid = 1'b1;
      res.code  = CODE_W'(ch - ASCII_LC_A);
    end
    if (res.code == CODE_J) begin
      res.code = CODE_I;
    end
    return res;
  endfunction

endpackage

### rtl/core/pfse_if.sv
// Input channel: one keyword byte, fill command or message byte per item.
interface pfse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output mode, output in_char, output end_of_text,
                  input ready);
  modport sink   (input valid, input mode, input in_char, input end_of_text,
                  output ready);
endinterface

// Result channel: one cipher letter per item.
interface pfse_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_letter;
  logic       last_of_run;
  logic       last_of_message;

  modport source (output valid, output cipher_letter, output last_of_run,
                  output last_of_message, input ready);
  modport sink   (input valid, input cipher_letter, input last_of_run,
                  input last_of_message, output ready);
endinterface

### rtl/core/pfse_cell_map.sv
// Shared Playfair rule unit: maps one letter of a pair to the cell that
// replaces it, given the position of the letter and of its partner.
module pfse_cell_map (
  input  pfse_pkg::pos_t               own_pos,
  input  pfse_pkg::pos_t               other_pos,
  output logic [pfse_pkg::CELL_W-1:0]  tgt_cell
);
  import pfse_pkg::*;

  logic [RC_W-1:0] row_next;
  logic [RC_W-1:0] col_next;
  logic [RC_W-1:0] tgt_row;
  logic [RC_W-1:0] tgt_col;

  // Step right or down with wrap-around.
  assign row_next = (own_pos.row == RC_W'(SQUARE_SIDE - 1)) ? '0 : own_pos.row + 1'b1;
  assign col_next = (own_pos.col == RC_W'(SQUARE_SIDE - 1)) ? '0 : own_pos.col + 1'b1;

  // Same row, then same column, otherwise the rectangle corner.
  always_comb begin
    if (own_pos.row == other_pos.row) begin
      tgt_row = own_pos.row;
      tgt_col = col_next;
    end else if (own_pos.col == other_pos.col) begin
      tgt_row = row_next;
      tgt_col = own_pos.col;
    end else begin
      tgt_row = own_pos.row;
      tgt_col = other_pos.col;
    end
  end

  assign tgt_cell = CELL_W'(CELL_W'(tgt_row) * CELL_W'(SQUARE_SIDE)) + CELL_W'(tgt_col);

endmodule

### rtl/core/playfair_stream_encryptor_core.sv
// Streaming Playfair encryptor. Keyword bytes (mode 0) build the 5x5 square;
// a fill command (mode 1) walks the alphabet once, and the block is not ready
// again until the walk is through. A message byte (mode 2) that does not
// complete a pair leaves the block ready for the next item. A byte that
// completes a pair, or closes a message with one letter left unpaired, starts
// the pair sequencer: two reads of the letter position table, two passes
// through the shared rule unit with a read of the square each, then the two
// cipher letters, one per cycle while the result side is ready. The single
// read ports of the position table and of the square make their reads take
// turns. The block takes no new item while it works on one or while its
// results wait to be taken. The square itself is not cleared at reset;
// encrypting before it is complete gives undefined letters.
module playfair_stream_encryptor_core (
  input  logic       clk,
  input  logic       rst_n,
  pfse_in_if.sink    in_ch,
  pfse_out_if.source out_ch
);
  import pfse_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_PA   = 4'd2;
  localparam logic [3:0] S_PB   = 4'd3;
  localparam logic [3:0] S_E1   = 4'd4;
  localparam logic [3:0] S_E2   = 4'd5;
  localparam logic [3:0] S_LD2  = 4'd6;
  localparam logic [3:0] S_OUT1 = 4'd7;
  localparam logic [3:0] S_OUT2 = 4'd8;

  // Control state.
  logic [3:0]          state_r, state_nxt;
  logic [ALPHABET-1:0] seen_r, seen_nxt;
  logic [CELL_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [RC_W-1:0]     fill_row_r, fill_row_nxt;
  logic [RC_W-1:0]     fill_col_r, fill_col_nxt;
  logic [CODE_W-1:0]   walk_r, walk_nxt;
  logic [5:0]          prev_r, prev_nxt;
  logic [CODE_W-1:0]   held_r, held_nxt;
  logic                pending_r, pending_nxt;

  // Pair operands and results.
  logic [CODE_W-1:0]   a_r, a_nxt;
  logic [CODE_W-1:0]   b_r, b_nxt;
  logic                final_r, final_nxt;
  pos_t                pa_r, pb_r;
  logic [CODE_W-1:0]   let1_r, let2_r;

  // Tables.
  logic [CODE_W-1:0]   sq_mem [SQUARE_CELLS];
  pos_t                pos_mem [ALPHABET];
  logic [CODE_W-1:0]   sq_q;
  pos_t                pos_q;

  logic                in_hs;
  letter_t             lt;
  logic [CODE_W-1:0]   msg_code;
  logic                append_en;
  logic [CODE_W-1:0]   append_code;
  logic                sq_full;
  pos_t                pos_gated;
  pos_t                map_own;
  pos_t                map_other;
  logic [CELL_W-1:0]   map_cell;
  logic [CODE_W-1:0]   pos_rd_addr;

  assign in_hs    = in_ch.valid && in_ch.ready;
  assign lt       = letter_decode(in_ch.in_char);
  assign sq_full  = (fill_cnt_r == CELL_W'(SQUARE_CELLS));
  assign msg_code = (lt.valid && ({1'b0, lt.code} == prev_r)) ? CODE_X : lt.code;

  // Square append: from a keyword byte or from the alphabet walk.
  always_comb begin
    append_en   = 1'b0;
    append_code = '0;
    if (state_r == S_IDLE && in_hs && in_ch.mode == MODE_KEY && lt.valid &&
        !seen_r[lt.code]) begin
      append_en   = 1'b1;
      append_code = lt.code;
    end else if (state_r == S_FILL && walk_r != CODE_J && !seen_r[walk_r]) begin
      append_en   = 1'b1;
      append_code = walk_r;
    end
    if (sq_full) begin
      append_en = 1'b0;
    end
  end

  // A letter never placed reads as the top left cell.
  assign pos_gated = seen_r[(state_r == S_PB) ? a_r : b_r] ? pos_q : '0;

  // Operands of the shared rule unit: first letter, then second letter.
  assign map_own   = (state_r == S_E1) ? pa_r      : pb_r;
  assign map_other = (state_r == S_E1) ? pos_gated : pa_r;

  pfse_cell_map u_cell_map (
    .own_pos   (map_own),
    .other_pos (map_other),
    .tgt_cell  (map_cell)
  );

  // Next-state logic of the sequencer and the message state.
  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    fill_cnt_nxt = fill_cnt_r;
    fill_row_nxt = fill_row_r;
    fill_col_nxt = fill_col_r;
    walk_nxt     = walk_r;
    prev_nxt     = prev_r;
    held_nxt     = held_r;
    pending_nxt  = pending_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    final_nxt    = final_r;

    if (append_en) begin
      seen_nxt[append_code] = 1'b1;
      fill_cnt_nxt          = fill_cnt_r + 1'b1;
      if (fill_col_r == RC_W'(SQUARE_SIDE - 1)) begin
        fill_col_nxt = '0;
        fill_row_nxt = fill_row_r + 1'b1;
      end else begin
        fill_col_nxt = fill_col_r + 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_hs && in_ch.mode == MODE_FILL) begin
          walk_nxt  = '0;
          state_nxt = S_FILL;
        end else if (in_hs && in_ch.mode == MODE_MSG) begin
          // A pair closes on a second letter, or on the end with one letter unpaired.
          if (lt.valid && pending_r) begin
            a_nxt     = held_r;
            b_nxt     = msg_code;
            final_nxt = in_ch.end_of_text;
            state_nxt = S_PA;
          end else if (in_ch.end_of_text && (pending_r || lt.valid)) begin
            a_nxt     = pending_r ? held_r : msg_code;
            b_nxt     = CODE_X;
            final_nxt = 1'b1;
            state_nxt = S_PA;
          end
          if (lt.valid) begin
            prev_nxt = {1'b0, msg_code};
            if (pending_r) begin
              pending_nxt = 1'b0;
            end else begin
              held_nxt    = msg_code;
              pending_nxt = 1'b1;
            end
          end
          if (in_ch.end_of_text) begin
            pending_nxt = 1'b0;
            held_nxt    = '0;
            prev_nxt    = NO_LETTER;
          end
        end
      end
      S_FILL: begin
        walk_nxt = walk_r + 1'b1;
        if (walk_r == CODE_Z) begin
          state_nxt = S_IDLE;
        end
      end
      S_PA:   state_nxt = S_PB;
      S_PB:   state_nxt = S_E1;
      S_E1:   state_nxt = S_E2;
      S_E2:   state_nxt = S_LD2;
      S_LD2:  state_nxt = S_OUT1;
      S_OUT1: begin
        if (out_ch.ready) begin
          state_nxt = S_OUT2;
        end
      end
      S_OUT2: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seen_r     <= '0;
      fill_cnt_r <= '0;
      fill_row_r <= '0;
      fill_col_r <= '0;
      walk_r     <= '0;
      prev_r     <= NO_LETTER;
      held_r     <= '0;
      pending_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seen_r     <= seen_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      fill_row_r <= fill_row_nxt;
      fill_col_r <= fill_col_nxt;
      walk_r     <= walk_nxt;
      prev_r     <= prev_nxt;
      held_r     <= held_nxt;
      pending_r  <= pending_nxt;
    end
  end

  // Pair payload registers.
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    final_r <= final_nxt;
    if (state_r == S_PB) begin
      pa_r <= pos_gated;
    end
    if (state_r == S_E1) begin
      pb_r <= pos_gated;
    end
    if (state_r == S_E2) begin
      let1_r <= sq_q;
    end
    if (state_r == S_LD2) begin
      let2_r <= sq_q;
    end
  end

  // Key square: written in fill order, read at the cell the rule unit picks.
  always_ff @(posedge clk) begin
    if (append_en) begin
      sq_mem[fill_cnt_r] <= append_code;
    end
    if (state_r == S_E1 || state_r == S_E2) begin
      sq_q <= sq_mem[map_cell];
    end
  end

  // Position table: row and column of each placed letter.
  assign pos_rd_addr = (state_r == S_PA) ? a_r : b_r;

  always_ff @(posedge clk) begin
    if (append_en) begin
      pos_mem[append_code] <= '{row: fill_row_r, col: fill_col_r};
    end
    if (state_r == S_PA || state_r == S_PB) begin
      pos_q <= pos_mem[pos_rd_addr];
    end
  end

  // Channel outputs.
  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = (state_r == S_OUT1) || (state_r == S_OUT2);
  assign out_ch.cipher_letter   = ASCII_UC_A[6:0] +
                                  {2'b00, (state_r == S_OUT2) ? let2_r : let1_r};
  assign out_ch.last_of_run     = (state_r == S_OUT2);
  assign out_ch.last_of_message = (state_r == S_OUT2) && final_r;

endmodule

### rtl/core/pfse_checker.sv
// Port-level checks of the encryptor.
module pfse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_cipher_letter,
  input logic       out_last_of_run,
  input logic       out_last_of_message
);

  // A waiting result item holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_letter) &&
    $stable(out_last_of_run) && $stable(out_last_of_message))
    else $error("result item changed while stalled");

  // No new item is taken while results are still waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // The end of a message always falls on the second letter of a pair.
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_message |-> out_last_of_run)
    else $error("message end outside a pair end");

  // The second letter of a pair follows the first at once.
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid && out_last_of_run)
    else $error("second letter of a pair missing");

  // After the second letter nothing is shown in the next cycle.
  a_pair_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> !out_valid)
    else $error("extra result after a pair");

endmodule

bind playfair_stream_encryptor_core pfse_checker u_pfse_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_cipher_letter   (out_ch.cipher_letter),
  .out_last_of_run     (out_ch.last_of_run),
  .out_last_of_message (out_ch.last_of_message)
);
